// ----- src/first_fit_block_allocator_top_assert.svh -----
// Assertion macros for the first-fit allocator.
// Used by first_fit_block_allocator_top; expand to nothing under SYNTHESIS.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge out of reset
`define FBA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// consequence that must hold in the cycle after the antecedent
`define FBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FBA_ASSERT(label, prop, msg)
`define FBA_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ----- src/fba_pkg.sv -----
// Shared types and codes for the first-fit allocator.
// No dependencies; used by fba_alu and first_fit_block_allocator_top.
`default_nettype none
package fba_pkg;

    localparam int BASE_W = 4;
    localparam int SIZE_W = 5;
    localparam int STAT_W = 3;

    // command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK     = 3'd0;
    localparam logic [STAT_W-1:0] STAT_NOFIT  = 3'd1;
    localparam logic [STAT_W-1:0] STAT_NOBASE = 3'd2;
    localparam logic [STAT_W-1:0] STAT_FULL   = 3'd3;
    localparam logic [STAT_W-1:0] STAT_ZERO   = 3'd4;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        logic              cmd;
        logic [SIZE_W-1:0] req_size;
        logic [BASE_W-1:0] free_base;
    } req_t;

    typedef struct packed {
        logic [BASE_W-1:0] granted_base;
        logic [STAT_W-1:0] status;
    } rsp_t;

endpackage
`default_nettype wire

// ----- src/fba_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module fba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ----- src/fba_alu.sv -----
// Shared add/subtract unit with equality compare for the allocator.
// Depends on fba_pkg (alu_op_t).
`default_nettype none
module fba_alu #(
    parameter int W = 5
) (
    input  wire fba_pkg::alu_op_t op,
    input  wire logic [W-1:0]     a,
    input  wire logic [W-1:0]     b,
    input  wire logic [W-1:0]     c,
    output logic      [W-1:0]     res,
    output logic                  carry,
    output logic                  eq
);

    logic [W:0] sum;

    // subtract is a + ~b + 1; carry out set means a >= b
    always_comb
    begin
        case (op)
            fba_pkg::ALU_ADD: sum = {1'b0, a} + {1'b0, b};
            fba_pkg::ALU_SUB: sum = {1'b0, a} + {1'b0, ~b} + {{W{1'b0}}, 1'b1};
            default:          sum = '0;
        endcase
    end

    assign res   = sum[W-1:0];
    assign carry = sum[W];
    assign eq    = (sum[W-1:0] == c);

endmodule
`default_nettype wire

// ----- src/first_fit_block_allocator_top.sv -----
// First-fit block allocator: extent and grant tables in RAMs, walked by a sequencer
// around one shared add/subtract/compare unit; one request in flight, ready only in idle.
// Allocate: accept, scan extents (read, then check), check grant slots, commit (subtract,
// then record and trim), move later extents up on removal (read, then write), hand off the word.
// Free: accept, scan grants (read and check each live one, skip empty slots), scan extents,
// update once found (grow or append), hand off. Reset: whole pool free, no grants.
`default_nettype none
`include "first_fit_block_allocator_top_assert.svh"
module first_fit_block_allocator_top #(
    parameter int POOL_WORDS  = 16,
    parameter int FREE_SLOTS  = 8,
    parameter int GRANT_SLOTS = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire fba_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output fba_pkg::rsp_t      rsp
);

    localparam int LW  = $clog2(POOL_WORDS + 1);
    localparam int CW  = (LW > fba_pkg::SIZE_W) ? LW : fba_pkg::SIZE_W;
    localparam int EAW = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
    localparam int GAW = (GRANT_SLOTS > 1) ? $clog2(GRANT_SLOTS) : 1;
    localparam int ECW = $clog2(FREE_SLOTS + 1);
    localparam int GCW = $clog2(GRANT_SLOTS + 1);
    localparam int IW  = (ECW > GCW) ? ECW : GCW;

    typedef enum logic [3:0] {
        S_IDLE,
        S_A_SCAN_RD,
        S_A_SCAN_CHK,
        S_A_SLOT,
        S_A_SUB,
        S_A_ADD,
        S_A_SHIFT_RD,
        S_A_SHIFT_WR,
        S_F_G_RD,
        S_F_G_CHK,
        S_F_E_RD,
        S_F_E_CHK,
        S_F_GROW,
        S_F_APPEND,
        S_DONE
    } state_t;

    state_t                 state_reg, state_next;
    logic [IW-1:0]          idx_reg, idx_next;
    logic [ECW-1:0]         ext_count_reg, ext_count_next;
    logic                   fresh_reg, fresh_next;
    logic                   rd_fresh_reg, rd_fresh_next;
    fba_pkg::req_t          req_reg, req_next;
    logic [EAW-1:0]         e_reg, e_next;
    logic [GAW-1:0]         g_reg, g_next;
    logic [LW-1:0]          cur_base_reg, cur_base_next;
    logic [LW-1:0]          cur_len_reg, cur_len_next;
    logic [LW-1:0]          glen_reg, glen_next;
    logic [LW-1:0]          rem_reg, rem_next;
    logic [GRANT_SLOTS-1:0] grant_valid_reg, grant_valid_next;
    fba_pkg::rsp_t          result_reg, result_next;
    fba_pkg::rsp_t          rsp_reg, rsp_next;
    logic                   rsp_valid_reg, rsp_valid_next;

    // RAM ports
    logic                ext_we;
    logic [EAW-1:0]      ext_waddr, ext_raddr;
    logic [2*LW-1:0]     ext_wdata, ext_rdata;
    logic                grant_we;
    logic [GAW-1:0]      grant_waddr, grant_raddr;
    logic [2*LW-1:0]     grant_wdata, grant_rdata;

    // shared unit
    fba_pkg::alu_op_t    alu_op;
    logic [CW-1:0]       alu_a, alu_b, alu_c, alu_res;
    logic                alu_carry, alu_eq;

    logic [LW-1:0]       ext_rd_base, ext_rd_len;

    fba_ram #(.WIDTH(2 * LW), .DEPTH(FREE_SLOTS)) u_ext_ram (
        .clk   (clk),
        .we    (ext_we),
        .waddr (ext_waddr),
        .wdata (ext_wdata),
        .raddr (ext_raddr),
        .rdata (ext_rdata)
    );

    fba_ram #(.WIDTH(2 * LW), .DEPTH(GRANT_SLOTS)) u_grant_ram (
        .clk   (clk),
        .we    (grant_we),
        .waddr (grant_waddr),
        .wdata (grant_wdata),
        .raddr (grant_raddr),
        .rdata (grant_rdata)
    );

    fba_alu #(.W(CW)) u_alu (
        .op    (alu_op),
        .a     (alu_a),
        .b     (alu_b),
        .c     (alu_c),
        .res   (alu_res),
        .carry (alu_carry),
        .eq    (alu_eq)
    );

    // entry 0 reads as the whole pool until it is first written
    assign ext_rd_base = rd_fresh_reg ? '0 : ext_rdata[2*LW-1:LW];
    assign ext_rd_len  = rd_fresh_reg ? LW'(POOL_WORDS) : ext_rdata[LW-1:0];

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        ext_count_next   = ext_count_reg;
        req_next         = req_reg;
        e_next           = e_reg;
        g_next           = g_reg;
        cur_base_next    = cur_base_reg;
        cur_len_next     = cur_len_reg;
        glen_next        = glen_reg;
        rem_next         = rem_reg;
        grant_valid_next = grant_valid_reg;
        result_next      = result_reg;
        rsp_next         = rsp_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp_ready;

        ext_we      = 1'b0;
        ext_waddr   = e_reg;
        ext_wdata   = '0;
        ext_raddr   = idx_reg[EAW-1:0];
        grant_we    = 1'b0;
        grant_waddr = g_reg;
        grant_wdata = {cur_base_reg, LW'(req_reg.req_size)};
        grant_raddr = idx_reg[GAW-1:0];

        alu_op = fba_pkg::ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;
        alu_c  = CW'(req_reg.free_base);

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next = req;
                    idx_next = '0;
                    result_next.granted_base = '0;
                    if (req.cmd == fba_pkg::CMD_FREE)
                    begin
                        state_next = S_F_G_RD;
                    end
                    else if (req.req_size == '0)
                    begin
                        result_next.status = fba_pkg::STAT_ZERO;
                        state_next         = S_DONE;
                    end
                    else
                    begin
                        state_next = S_A_SCAN_RD;
                    end
                end
            end

            // allocate: find the first extent that is long enough
            S_A_SCAN_RD:
            begin
                if (idx_reg == IW'(ext_count_reg))
                begin
                    result_next.status = fba_pkg::STAT_NOFIT;
                    state_next         = S_DONE;
                end
                else
                begin
                    state_next = S_A_SCAN_CHK;
                end
            end

            S_A_SCAN_CHK:
            begin
                alu_op = fba_pkg::ALU_SUB;
                alu_a  = CW'(ext_rd_len);
                alu_b  = CW'(req_reg.req_size);
                if (alu_carry)
                begin
                    cur_base_next = ext_rd_base;
                    cur_len_next  = ext_rd_len;
                    e_next        = idx_reg[EAW-1:0];
                    idx_next      = '0;
                    state_next    = S_A_SLOT;
                end
                else
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = S_A_SCAN_RD;
                end
            end

            // allocate: lowest empty grant slot
            S_A_SLOT:
            begin
                if (idx_reg == IW'(GRANT_SLOTS))
                begin
                    result_next.status = fba_pkg::STAT_FULL;
                    state_next         = S_DONE;
                end
                else if (!grant_valid_reg[idx_reg[GAW-1:0]])
                begin
                    g_next     = idx_reg[GAW-1:0];
                    state_next = S_A_SUB;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end

            S_A_SUB:
            begin
                alu_op     = fba_pkg::ALU_SUB;
                alu_a      = CW'(cur_len_reg);
                alu_b      = CW'(req_reg.req_size);
                rem_next   = LW'(alu_res);
                state_next = S_A_ADD;
            end

            // allocate: record the grant and trim the extent from the front, removing it once empty
            S_A_ADD:
            begin
                alu_a    = CW'(cur_base_reg);
                alu_b    = CW'(req_reg.req_size);
                grant_we = 1'b1;
                grant_valid_next[g_reg]  = 1'b1;
                result_next.granted_base = fba_pkg::BASE_W'(cur_base_reg);
                result_next.status       = fba_pkg::STAT_OK;
                if (rem_reg == '0)
                begin
                    if ((IW'(e_reg) + IW'(1)) < IW'(ext_count_reg))
                    begin
                        idx_next   = IW'(e_reg);
                        state_next = S_A_SHIFT_RD;
                    end
                    else
                    begin
                        ext_count_next = ext_count_reg - ECW'(1);
                        state_next     = S_DONE;
                    end
                end
                else
                begin
                    ext_we     = 1'b1;
                    ext_wdata  = {LW'(alu_res), rem_reg};
                    state_next = S_DONE;
                end
            end

            // removal: move later extents up one entry
            S_A_SHIFT_RD:
            begin
                ext_raddr  = EAW'(idx_reg + IW'(1));
                state_next = S_A_SHIFT_WR;
            end

            S_A_SHIFT_WR:
            begin
                ext_we    = 1'b1;
                ext_waddr = idx_reg[EAW-1:0];
                ext_wdata = ext_rdata;
                idx_next  = idx_reg + IW'(1);
                if ((idx_reg + IW'(1)) < (IW'(ext_count_reg) - IW'(1)))
                begin
                    state_next = S_A_SHIFT_RD;
                end
                else
                begin
                    ext_count_next = ext_count_reg - ECW'(1);
                    state_next     = S_DONE;
                end
            end

            // free: lowest valid grant with the given base
            S_F_G_RD:
            begin
                if (idx_reg == IW'(GRANT_SLOTS))
                begin
                    result_next.status = fba_pkg::STAT_NOBASE;
                    state_next         = S_DONE;
                end
                else if (grant_valid_reg[idx_reg[GAW-1:0]])
                begin
                    state_next = S_F_G_CHK;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end

            S_F_G_CHK:
            begin
                alu_a = CW'(grant_rdata[2*LW-1:LW]);
                if (alu_eq)
                begin
                    g_next     = idx_reg[GAW-1:0];
                    glen_next  = grant_rdata[LW-1:0];
                    idx_next   = '0;
                    state_next = S_F_E_RD;
                end
                else
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = S_F_G_RD;
                end
            end

            // free: first extent that ends at the base
            S_F_E_RD:
            begin
                if (idx_reg == IW'(ext_count_reg))
                begin
                    state_next = S_F_APPEND;
                end
                else
                begin
                    state_next = S_F_E_CHK;
                end
            end

            S_F_E_CHK:
            begin
                alu_a = CW'(ext_rd_base);
                alu_b = CW'(ext_rd_len);
                if (alu_eq)
                begin
                    cur_base_next = ext_rd_base;
                    cur_len_next  = ext_rd_len;
                    e_next        = idx_reg[EAW-1:0];
                    state_next    = S_F_GROW;
                end
                else
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = S_F_E_RD;
                end
            end

            S_F_GROW:
            begin
                alu_a     = CW'(cur_len_reg);
                alu_b     = CW'(glen_reg);
                ext_we    = 1'b1;
                ext_wdata = {cur_base_reg, LW'(alu_res)};
                grant_valid_next[g_reg] = 1'b0;
                result_next.status      = fba_pkg::STAT_OK;
                state_next              = S_DONE;
            end

            S_F_APPEND:
            begin
                if (ext_count_reg == ECW'(FREE_SLOTS))
                begin
                    result_next.status = fba_pkg::STAT_FULL;
                end
                else
                begin
                    ext_we         = 1'b1;
                    ext_waddr      = EAW'(ext_count_reg);
                    ext_wdata      = {LW'(req_reg.free_base), glen_reg};
                    ext_count_next = ext_count_reg + ECW'(1);
                    grant_valid_next[g_reg] = 1'b0;
                    result_next.status      = fba_pkg::STAT_OK;
                end
                state_next = S_DONE;
            end

            // hand the result word to the output register once it is free
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next       = result_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        fresh_next    = fresh_reg && !(ext_we && (ext_waddr == '0));
        rd_fresh_next = fresh_reg && (ext_raddr == '0);
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            idx_reg         <= '0;
            ext_count_reg   <= ECW'(1);
            fresh_reg       <= 1'b1;
            rd_fresh_reg    <= 1'b0;
            req_reg         <= '0;
            e_reg           <= '0;
            g_reg           <= '0;
            cur_base_reg    <= '0;
            cur_len_reg     <= '0;
            glen_reg        <= '0;
            rem_reg         <= '0;
            grant_valid_reg <= '0;
            result_reg      <= '0;
            rsp_reg         <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            ext_count_reg   <= ext_count_next;
            fresh_reg       <= fresh_next;
            rd_fresh_reg    <= rd_fresh_next;
            req_reg         <= req_next;
            e_reg           <= e_next;
            g_reg           <= g_next;
            cur_base_reg    <= cur_base_next;
            cur_len_reg     <= cur_len_next;
            glen_reg        <= glen_next;
            rem_reg         <= rem_next;
            grant_valid_reg <= grant_valid_next;
            result_reg      <= result_next;
            rsp_reg         <= rsp_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // checks
    `FBA_ASSERT(a_count_max, ext_count_reg <= ECW'(FREE_SLOTS), "extent count above table size")
    `FBA_ASSERT(a_scan_live, ((state_reg == S_A_SCAN_CHK) || (state_reg == S_F_E_CHK)) |-> (idx_reg < IW'(ext_count_reg)), "extent scan past count")
    `FBA_ASSERT(a_grant_empty, grant_we |-> !grant_valid_reg[g_reg], "grant written over a live slot")
    `FBA_ASSERT_NEXT(a_busy, req_valid && req_ready, !req_ready, "accepted while a request is in flight")

endmodule
`default_nettype wire
